>>> rtl/gnsu_pkg.sv
// Shared types and constants of the GLIF neuron state update block.
// Micro-op codes, the controller command bundle, the datapath status bundle.
// No dependencies.
package gnsu_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_HARD_RESET = 2'd0;
  localparam logic [1:0] CFG_STEP_SIZE  = 2'd1;
  localparam logic [1:0] CFG_RESET_V    = 2'd2;

  // Input command codes.
  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Micro-ops of one neuron step, in issue order.
  typedef enum logic [4:0] {
    U_AC0, U_AC1,
    U_BSD, U_BS2, U_BR3, U_BRD, U_BRX, U_BPD, U_BPS,
    U_DECAY, U_HARD, U_RCOEF, U_ASF, U_RSUB, U_TREF,
    U_ADEC0, U_AAMP0, U_ADEC1, U_AAMP1
  } uop_t;

  typedef struct packed {
    logic       accept;  // input beat taken this cycle
    logic       start;   // clear accumulators before the first micro-op
    logic       run;     // micro-op sequence active
    uop_t       uop;
    logic [1:0] sub;     // 0: param address, 1: multiply, 2: accumulate
    logic [2:0] basis;
    logic       wb;      // write state back and load the output register
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic in_ok;     // neuron index in range
    logic out_busy;  // output register full and not taken this cycle
  } stat_t;

  // Parameter word number used by a micro-op.
  function automatic logic [5:0] word_of(uop_t u, logic [2:0] k, int bases);
    logic [5:0] b4;
    logic [5:0] kb;
    logic [5:0] w;
    b4 = 6'(4 * bases);
    kb = {1'b0, k, 2'b00};
    case (u)
      U_AC0:   w = b4 + 6'd5;
      U_AC1:   w = b4 + 6'd6;
      U_BSD:   w = kb;
      U_BS2:   w = kb + 6'd2;
      U_BR3:   w = kb + 6'd3;
      U_BRD:   w = kb;
      U_BRX:   w = kb + 6'd1;
      U_BPD:   w = kb;
      U_DECAY: w = b4 + 6'd4;
      U_HARD:  w = b4 + 6'd4;
      U_RCOEF: w = b4 + 6'd7;
      U_ASF:   w = b4 + 6'd8;
      U_RSUB:  w = b4 + 6'd7;
      U_TREF:  w = b4 + 6'd9;
      U_ADEC0: w = b4;
      U_AAMP0: w = b4 + 6'd2;
      U_ADEC1: w = b4 + 6'd1;
      U_AAMP1: w = b4 + 6'd3;
      default: w = kb;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/gnsu_ctrl.sv
// Controller of the GLIF neuron state update: clear wait, accept, micro-op
// sequencing and write-back. Depends on gnsu_pkg.
module gnsu_ctrl
  import gnsu_pkg::*;
#(
  parameter int BASES = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_cmd,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_LOAD, S_RUN, S_WB} state_t;

  state_t     state_r;
  uop_t       uop_r;
  logic [1:0] sub_r;
  logic [2:0] basis_r;

  always_comb begin
    in_ready   = (state_r == S_IDLE);
    cmd.accept = in_valid && in_ready;
    cmd.start  = (state_r == S_LOAD);
    cmd.run    = (state_r == S_RUN);
    cmd.uop    = uop_r;
    cmd.sub    = sub_r;
    cmd.basis  = basis_r;
    cmd.wb     = (state_r == S_WB) && !stat.out_busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      uop_r   <= U_AC0;
      sub_r   <= 2'd0;
      basis_r <= 3'd0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          if (stat.clear_done) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd.accept && in_cmd == CMD_STEP && stat.in_ok) state_r <= S_LOAD;
        end
        S_LOAD: begin
          uop_r   <= U_AC0;
          sub_r   <= 2'd0;
          basis_r <= 3'd0;
          state_r <= S_RUN;
        end
        S_RUN: begin
          if (sub_r != 2'd2) begin
            sub_r <= sub_r + 2'd1;
          end else begin
            sub_r <= 2'd0;
            if (uop_r == U_BPS) begin
              if (basis_r == 3'(BASES - 1)) begin
                basis_r <= 3'd0;
                uop_r   <= U_DECAY;
              end else begin
                basis_r <= basis_r + 3'd1;
                uop_r   <= U_BSD;
              end
            end else if (uop_r == U_AAMP1) begin
              state_r <= S_WB;
            end else begin
              uop_r <= uop_t'(uop_r + 5'd1);
            end
          end
        end
        S_WB: begin
          if (cmd.wb) state_r <= S_IDLE;
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

endmodule

>>> rtl/gnsu_dp.sv
// Datapath of the GLIF neuron state update: state and parameter memories,
// shared multiplier, accumulators and output register. Depends on gnsu_pkg.
module gnsu_dp
  import gnsu_pkg::*;
#(
  parameter int NEURONS   = 1024,
  parameter int BASES     = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        hard_mode,
  input  logic [30:0] step_size,
  input  logic [31:0] reset_voltage,
  input  logic        in_cmd,
  input  logic [9:0]  in_neuron,
  input  logic        in_spike,
  input  logic [31:0] in_syn_in_0,
  input  logic [31:0] in_syn_in_1,
  input  logic [31:0] in_syn_in_2,
  input  logic [31:0] in_syn_in_3,
  input  logic [4:0]  in_param_select,
  input  logic [31:0] in_param_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_neuron_out,
  output logic [31:0] out_membrane_v,
  output logic [14:0] out_refractory_left,
  output logic [31:0] out_asc_0,
  output logic [31:0] out_asc_1
);

  localparam int WORDS = 4 * BASES + 10;
  localparam int NW    = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int KW    = (BASES > 1) ? $clog2(BASES) : 1;
  localparam int PAW   = (NEURONS * WORDS > 1) ? $clog2(NEURONS * WORDS) : 1;
  localparam int RW    = 32 * BASES;

  function automatic logic [31:0] sat32(logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'h7FFF_FFFF;
    if (x < -66'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  // memories
  logic [31:0]   mem_v    [NEURONS];
  logic [14:0]   mem_refr [NEURONS];
  logic [63:0]   mem_cur  [NEURONS];
  logic [RW-1:0] mem_rise [NEURONS];
  logic [RW-1:0] mem_psc  [NEURONS];
  logic [31:0]   ptab     [NEURONS * WORDS];

  logic [31:0]   v_q;
  logic [14:0]   refr_q;
  logic [63:0]   cur_q;
  logic [RW-1:0] rise_q;
  logic [RW-1:0] psc_q;
  logic [31:0]   pdata_r;

  logic [NW-1:0] clr_cnt_r;
  logic          clr_done_r;
  logic [NW-1:0] n_r;
  logic          spk_r;
  logic [31:0]   x_r [BASES];
  logic [31:0]   syn_arr [4];

  logic signed [65:0] prod_r;
  logic signed [39:0] drive_r;
  logic signed [39:0] acc_r;
  logic [31:0]        sd_r;
  logic [14:0]        refr_new_r;
  logic [31:0]        rise_new_r [BASES];
  logic [31:0]        psc_new_r  [BASES];
  logic [31:0]        cur_new_r  [2];
  logic               out_valid_r;

  logic [KW-1:0]      k;
  logic [PAW-1:0]     raddr;
  logic [PAW-1:0]     waddr;
  logic [NW-1:0]      saddr;
  logic [NW-1:0]      in_idx;
  logic signed [32:0] m_a;
  logic signed [32:0] m_b;
  logic signed [65:0] rnd;
  logic [31:0]        val;
  logic               hs;
  logic signed [33:0] refr_sum;
  logic [31:0]        volt_fin;
  logic [RW-1:0]      rise_row;
  logic [RW-1:0]      psc_row;
  logic [31:0]        rise_k;
  logic [31:0]        psc_k;

  assign syn_arr[0] = in_syn_in_0;
  assign syn_arr[1] = in_syn_in_1;
  assign syn_arr[2] = in_syn_in_2;
  assign syn_arr[3] = in_syn_in_3;

  assign k      = cmd.basis[KW-1:0];
  assign in_idx = NW'(in_neuron);
  assign raddr  = PAW'(n_r) * PAW'(WORDS) + PAW'(word_of(cmd.uop, cmd.basis, BASES));
  assign waddr  = PAW'(in_idx) * PAW'(WORDS) + PAW'(in_param_select);
  assign saddr  = clr_done_r ? n_r : clr_cnt_r;
  assign hs     = hard_mode && spk_r;
  assign rise_k = rise_q[32 * k +: 32];
  assign psc_k  = psc_q[32 * k +: 32];

  assign stat.clear_done = clr_done_r;
  assign stat.in_ok      = ({22'd0, in_neuron} < 32'(NEURONS));
  assign stat.out_busy   = out_valid_r && !out_ready;

  // clearing pass over all state rows after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_done_r <= 1'b0;
    end else if (!clr_done_r) begin
      if (clr_cnt_r == NW'(NEURONS - 1)) clr_done_r <= 1'b1;
      else clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < BASES; i++) begin
      rise_row[32 * i +: 32] = rise_new_r[i];
      psc_row[32 * i +: 32]  = psc_new_r[i];
    end
  end

  assign volt_fin = (hard_mode && refr_new_r != 15'd0) ? reset_voltage
                                                       : sat32(66'(drive_r));

  // state memories: clear or write back, read at the current neuron
  always_ff @(posedge clk) begin
    if (!clr_done_r || cmd.wb) begin
      mem_v[saddr]    <= clr_done_r ? volt_fin : '0;
      mem_refr[saddr] <= clr_done_r ? refr_new_r : '0;
      mem_cur[saddr]  <= clr_done_r ? {cur_new_r[1], cur_new_r[0]} : '0;
      mem_rise[saddr] <= clr_done_r ? rise_row : '0;
      mem_psc[saddr]  <= clr_done_r ? psc_row : '0;
    end
    v_q    <= mem_v[n_r];
    refr_q <= mem_refr[n_r];
    cur_q  <= mem_cur[n_r];
    rise_q <= mem_rise[n_r];
    psc_q  <= mem_psc[n_r];
  end

  // parameter table
  always_ff @(posedge clk) begin
    if (cmd.accept && in_cmd == CMD_WRITE && stat.in_ok &&
        {27'd0, in_param_select} < 32'(WORDS)) begin
      ptab[waddr] <= in_param_value;
    end
    pdata_r <= ptab[raddr];
  end

  // capture a step item
  always_ff @(posedge clk) begin
    if (cmd.accept && in_cmd == CMD_STEP) begin
      n_r   <= in_idx;
      spk_r <= in_spike;
      for (int i = 0; i < BASES; i++) begin
        x_r[i] <= (i < 4) ? syn_arr[i % 4] : 32'd0;
      end
    end
  end

  // multiplier operands
  always_comb begin
    m_a = (cmd.uop == U_BPS) ? 33'(signed'(sd_r)) : 33'(signed'(pdata_r));
    case (cmd.uop)
      U_AC0, U_ADEC0: m_b = 33'(signed'(cur_q[31:0]));
      U_AC1, U_ADEC1: m_b = 33'(signed'(cur_q[63:32]));
      U_BSD:          m_b = signed'({2'b00, step_size});
      U_BS2, U_BPD:   m_b = 33'(signed'(psc_k));
      U_BR3, U_BRD,
      U_BPS:          m_b = 33'(signed'(rise_k));
      U_BRX:          m_b = 33'(signed'(x_r[k]));
      U_DECAY:        m_b = 33'(signed'(v_q));
      U_HARD:         m_b = signed'({reset_voltage[31], reset_voltage})
                          - signed'({v_q[31], v_q});
      default:        m_b = '0;
    endcase
    rnd      = prod_r + (66'sd1 <<< (FRAC_BITS - 1));
    val      = sat32(rnd >>> FRAC_BITS);
    refr_sum = signed'({19'd0, refr_q})
             + (spk_r ? 34'(signed'(pdata_r)) : 34'sd0) - 34'sd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      drive_r <= '0;
      acc_r   <= '0;
    end
    if (cmd.run && cmd.sub == 2'd1) prod_r <= m_a * m_b;
    if (cmd.run && cmd.sub == 2'd2) begin
      case (cmd.uop)
        U_AC0, U_AC1, U_BS2, U_BR3, U_DECAY:
          drive_r <= drive_r + 40'(signed'(val));
        U_HARD:
          if (hs) drive_r <= drive_r + 40'(signed'(val));
        U_RCOEF, U_ASF:
          if (spk_r) drive_r <= drive_r + 40'(signed'(pdata_r));
        U_RSUB:
          if (hs) drive_r <= drive_r - 40'(signed'(pdata_r));
        U_BSD:
          sd_r <= val;
        U_BRD, U_BPD, U_ADEC0, U_ADEC1:
          acc_r <= 40'(signed'(val));
        U_BRX:
          rise_new_r[k] <= sat32(66'(acc_r + 40'(signed'(val))));
        U_BPS:
          psc_new_r[k] <= sat32(66'(acc_r + 40'(signed'(val))));
        U_AAMP0:
          cur_new_r[0] <= sat32(66'(acc_r + (spk_r ? 40'(signed'(pdata_r)) : 40'sd0)));
        U_AAMP1:
          cur_new_r[1] <= sat32(66'(acc_r + (spk_r ? 40'(signed'(pdata_r)) : 40'sd0)));
        U_TREF: begin
          if (refr_sum < 34'sd0) refr_new_r <= 15'd0;
          else if (refr_sum > 34'sd32767) refr_new_r <= 15'h7FFF;
          else refr_new_r <= refr_sum[14:0];
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.wb) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.wb) begin
      out_neuron_out      <= 10'(n_r);
      out_membrane_v      <= volt_fin;
      out_refractory_left <= refr_new_r;
      out_asc_0           <= cur_new_r[0];
      out_asc_1           <= cur_new_r[1];
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/glif_neuron_state_update.sv
// GLIF neuron state update, top level. One shared multiplier takes every product
// in turn; one step is in flight at a time, and no new beat is taken until its
// result has been written back. After reset a clearing pass zeroes all neuron
// state; no input beat is taken until it ends.
// Depends on gnsu_pkg, gnsu_ctrl and gnsu_dp.
module glif_neuron_state_update
  import gnsu_pkg::*;
#(
  parameter int NEURONS   = 1024,
  parameter int BASES     = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [9:0]  in_neuron,
  input  logic        in_spike,
  input  logic [31:0] in_syn_in_0,
  input  logic [31:0] in_syn_in_1,
  input  logic [31:0] in_syn_in_2,
  input  logic [31:0] in_syn_in_3,
  input  logic [4:0]  in_param_select,
  input  logic [31:0] in_param_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_neuron_out,
  output logic [31:0] out_membrane_v,
  output logic [14:0] out_refractory_left,
  output logic [31:0] out_asc_0,
  output logic [31:0] out_asc_1,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic        hard_mode_r;
  logic [30:0] step_size_r;
  logic [31:0] reset_v_r;
  cmd_t        cmd;
  stat_t       stat;

  // Configuration beats are always taken; writes beyond the last register drop.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hard_mode_r <= 1'b0;
      step_size_r <= 31'd65536;
      reset_v_r   <= 32'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HARD_RESET: hard_mode_r <= cfg_data[0];
        CFG_STEP_SIZE:  step_size_r <= cfg_data[30:0];
        CFG_RESET_V:    reset_v_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequence micro-ops: each takes address, multiply and accumulate cycles.
  gnsu_ctrl #(.BASES(BASES)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the neuron memories, the parameter table and the output register.
  gnsu_dp #(
    .NEURONS   (NEURONS),
    .BASES     (BASES),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .hard_mode           (hard_mode_r),
    .step_size           (step_size_r),
    .reset_voltage       (reset_v_r),
    .in_cmd              (in_cmd),
    .in_neuron           (in_neuron),
    .in_spike            (in_spike),
    .in_syn_in_0         (in_syn_in_0),
    .in_syn_in_1         (in_syn_in_1),
    .in_syn_in_2         (in_syn_in_2),
    .in_syn_in_3         (in_syn_in_3),
    .in_param_select     (in_param_select),
    .in_param_value      (in_param_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_neuron_out      (out_neuron_out),
    .out_membrane_v      (out_membrane_v),
    .out_refractory_left (out_refractory_left),
    .out_asc_0           (out_asc_0),
    .out_asc_1           (out_asc_1)
  );

  // No beat is taken before the clearing pass is over.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.clear_done |-> !in_ready)
    else $error("input taken during clearing pass");

  // In hard-reset mode a refractory neuron reports the reset voltage.
  a_hard_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && hard_mode_r && out_refractory_left != 15'd0 |->
      out_membrane_v == reset_v_r)
    else $error("refractory membrane not clamped");

  // A write-back never overwrites a result still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb |-> !out_valid || out_ready)
    else $error("result overwritten");

endmodule

>>> tb/sv/tb_glif_neuron_state_update.sv
// Self-checking testbench of the GLIF neuron state update block.
// Holds its own fixed-point predictor of the neuron step; depends on gnsu_pkg
// and the glif_neuron_state_update RTL.
module tb_glif_neuron_state_update;
  import gnsu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NEURONS = 1024;
  localparam int BASES   = 4;
  localparam int WORDS   = 4 * BASES + 10;
  localparam int W_ADEC  = 4 * BASES + 0;
  localparam int W_AAMP  = 4 * BASES + 2;
  localparam int W_DECAY = 4 * BASES + 4;
  localparam int W_AFAC  = 4 * BASES + 5;
  localparam int W_RCOEF = 4 * BASES + 7;
  localparam int W_ASF   = 4 * BASES + 8;
  localparam int W_TREF  = 4 * BASES + 9;
  localparam logic [1:0] CFG_SPARE = 2'd3;  // unmapped register index
  localparam int STEP_LAT  = 3 * (7 * BASES + 12) + 3;
  localparam int DRAIN_CYC = STEP_LAT + 20;
  localparam int MAX_CYC   = 1000000;
  localparam int POOL_N    = 8;
  localparam int RAND_PER_PHASE = 120;

  typedef struct {
    logic        cmd;
    logic [9:0]  neuron;
    logic        spike;
    logic [31:0] syn [4];
    logic [4:0]  sel;
    logic [31:0] val;
  } beat_t;

  typedef struct {
    logic [9:0]  neuron;
    logic [31:0] v;
    logic [14:0] refr;
    logic [31:0] asc0;
    logic [31:0] asc1;
  } nstate_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = CMD_STEP;
  logic [9:0] in_neuron = '0;
  logic in_spike = 1'b0;
  logic [31:0] in_syn_in_0 = '0, in_syn_in_1 = '0, in_syn_in_2 = '0, in_syn_in_3 = '0;
  logic [4:0] in_param_select = '0;
  logic [31:0] in_param_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [9:0] out_neuron_out;
  logic [31:0] out_membrane_v, out_asc_0, out_asc_1;
  logic [14:0] out_refractory_left;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_HARD_RESET;
  logic [31:0] cfg_data = '0;

  glif_neuron_state_update u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the configuration and all neuron state.
  bit      hard_mode;
  longint  dt_fx;
  longint  v_reset;
  int      memb    [NEURONS];
  int      refr_st [NEURONS];
  int      asc_st  [2 * NEURONS];
  int      rise_st [BASES * NEURONS];
  int      psc_st  [BASES * NEURONS];
  int      prm     [NEURONS * WORDS];

  beat_t   pending_beats[$];
  nstate_t expected_states[$];
  int      errors, n_sent, n_acc, n_steps, n_writes, n_spikes, n_results;
  int      pool [POOL_N];

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Exact product, round half up at the binary point (arithmetic shift floors).
  function automatic longint mul_round(longint a, longint b);
    return (a * b + 64'sd32768) >>> 16;
  endfunction

  function automatic longint mul_sat(longint a, longint b);
    return sat32(mul_round(a, b));
  endfunction

  // Apply one accepted beat to the predictor; a step beat advances its neuron and queues its result.
  function automatic void advance_neuron(beat_t b);
    int n, pb, j;
    longint v, drive, volt, r, r0, s0, x, sd, a;
    nstate_t res;
    n = b.neuron;
    pb = n * WORDS;
    if (b.cmd == CMD_WRITE) begin
      n_writes++;
      if (b.sel < WORDS) begin
        prm[pb + b.sel] = b.val;
      end
      return;
    end
    n_steps++;
    if (b.spike) n_spikes++;
    v = memb[n];
    drive = mul_sat(prm[pb + W_AFAC], asc_st[2 * n]) +
            mul_sat(prm[pb + W_AFAC + 1], asc_st[2 * n + 1]);
    for (int k = 0; k < BASES; k++) begin
      j = n * BASES + k;
      r0 = rise_st[j];
      s0 = psc_st[j];
      x = longint'($signed(b.syn[k]));
      sd = mul_sat(dt_fx, prm[pb + 4 * k]);
      drive += mul_sat(prm[pb + 4 * k + 2], s0) + mul_sat(prm[pb + 4 * k + 3], r0);
      rise_st[j] = int'(sat32(mul_sat(r0, prm[pb + 4 * k]) + mul_sat(x, prm[pb + 4 * k + 1])));
      psc_st[j]  = int'(sat32(mul_sat(s0, prm[pb + 4 * k]) + mul_sat(sd, r0)));
    end
    r = longint'(refr_st[n]) + (b.spike ? longint'(prm[pb + W_TREF]) : 0) - 1;
    if (r < 0) r = 0;
    if (r > 32767) r = 32767;
    volt = mul_sat(prm[pb + W_DECAY], v) + drive;
    if (b.spike) volt += longint'(prm[pb + W_RCOEF]) + longint'(prm[pb + W_ASF]);
    if (hard_mode && b.spike)
      volt += sat32(mul_round(v_reset - v, prm[pb + W_DECAY])) - longint'(prm[pb + W_RCOEF]);
    if (hard_mode && r > 0) volt = v_reset;
    memb[n] = int'(sat32(volt));
    refr_st[n] = int'(r);
    for (int k = 0; k < 2; k++) begin
      a = mul_sat(prm[pb + W_ADEC + k], asc_st[2 * n + k]);
      if (b.spike) a += mul_sat(64'sd65536, prm[pb + W_AAMP + k]);
      asc_st[2 * n + k] = int'(sat32(a));
    end
    res.neuron = b.neuron;
    res.v = memb[n];
    res.refr = r[14:0];
    res.asc0 = asc_st[2 * n];
    res.asc1 = asc_st[2 * n + 1];
    expected_states.push_back(res);
  endfunction

  // Input driver: one beat in flight, random gap before each beat, calm stretches.
  int  in_gap, in_run;
  bit  in_calm;
  beat_t in_cur;
  always @(posedge clk) begin
    bit hold;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      hold = in_valid;
      if (in_valid && in_ready) begin
        advance_neuron(in_cur);
        n_acc++;
        hold = 0;
      end
      if (!hold) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_beats.size() > 0) begin
          in_cur = pending_beats.pop_front();
          in_cmd          <= in_cur.cmd;
          in_neuron       <= in_cur.neuron;
          in_spike        <= in_cur.spike;
          in_syn_in_0     <= in_cur.syn[0];
          in_syn_in_1     <= in_cur.syn[1];
          in_syn_in_2     <= in_cur.syn[2];
          in_syn_in_3     <= in_cur.syn[3];
          in_param_select <= in_cur.sel;
          in_param_value  <= in_cur.val;
          hold = 1;
          if (in_run == 0) begin
            in_run = $urandom_range(10, 40);
            in_calm = ($urandom_range(0, 2) == 0);
          end
          in_run--;
          in_gap = in_calm ? 0 : $urandom_range(0, 12);
        end
      end
      in_valid <= hold;
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
    end
  endfunction

  // Result monitor: compare each beat with the oldest expectation, stall at random.
  int out_hold, out_run;
  bit out_calm;
  always @(posedge clk) begin
    nstate_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_states.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none actual neuron %0d",
                   $time, out_neuron_out);
        end else begin
          e = expected_states.pop_front();
          check_field("neuron_out", e.neuron, out_neuron_out);
          check_field("membrane_v", e.v, out_membrane_v);
          check_field("refractory_left", e.refr, out_refractory_left);
          check_field("asc_0", e.asc0, out_asc_0);
          check_field("asc_1", e.asc1, out_asc_1);
        end
        if (out_run == 0) begin
          out_run = $urandom_range(10, 40);
          out_calm = ($urandom_range(0, 2) == 0);
        end
        out_run--;
        out_hold = out_calm ? 0 : $urandom_range(0, 12);
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_ready <= (out_hold == 0);
    end
  end

  // Watchdog.
  int cycles;
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYC) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Parameter words: mostly near unity scale, some full range; t_ref mostly short.
  function automatic logic [31:0] rand_param(int sel);
    if (sel == W_TREF)
      return ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 8);
    if ($urandom_range(0, 2) == 0) return $urandom();
    return $urandom_range(0, 262144) - 131072;
  endfunction

  function automatic logic [31:0] rand_syn();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom_range(0, 1 << 20) - (1 << 19);
    endcase
  endfunction

  task automatic push_beat(logic cmd, int n, logic spk, logic [31:0] s0, logic [31:0] s1,
                           logic [31:0] s2, logic [31:0] s3, int sel, logic [31:0] val);
    beat_t b;
    b.cmd = cmd;
    b.neuron = 10'(n);
    b.spike = spk;
    b.syn[0] = s0;
    b.syn[1] = s1;
    b.syn[2] = s2;
    b.syn[3] = s3;
    b.sel = 5'(sel);
    b.val = val;
    pending_beats.push_back(b);
    n_sent++;
  endtask

  task automatic push_step(int n, logic spk);
    push_beat(CMD_STEP, n, spk, rand_syn(), rand_syn(), rand_syn(), rand_syn(),
              $urandom_range(0, 31), $urandom());
  endtask

  task automatic push_write(int n, int sel, logic [31:0] val);
    push_beat(CMD_WRITE, n, 1'($urandom_range(0, 1)), $urandom(), $urandom(), $urandom(),
              $urandom(), sel, val);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_HARD_RESET: hard_mode = data[0];
      CFG_STEP_SIZE:  dt_fx = longint'(data[30:0]);
      CFG_RESET_V:    v_reset = longint'($signed(data));
      default: ;
    endcase
  endtask

  // Block until every beat is taken and every result is back, then let it settle.
  task automatic drain();
    do @(negedge clk); while (n_acc != n_sent || expected_states.size() != 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic random_phase();
    int n, pick;
    for (int i = 0; i < RAND_PER_PHASE; i++) begin
      pick = $urandom_range(0, 99);
      n = pool[$urandom_range(0, POOL_N - 1)];
      if (pick < 70) begin
        push_step(n, $urandom_range(0, 9) < 3);
      end else if (pick < 85) begin
        pick = $urandom_range(0, WORDS - 1);
        push_write(n, pick, rand_param(pick));
      end else begin
        // noise: arbitrary neuron, possibly an unmapped word
        push_write($urandom_range(0, NEURONS - 1), $urandom_range(0, 31), $urandom());
      end
    end
  endtask

  initial begin
    hard_mode = 0;
    dt_fx = 65536;
    v_reset = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Pool of stepped neurons, both index extremes included, every word loaded.
    pool[0] = 0;
    pool[1] = NEURONS - 1;
    for (int i = 2; i < POOL_N; i++) pool[i] = $urandom_range(1, NEURONS - 2);
    for (int i = 0; i < POOL_N; i++)
      for (int w = 0; w < WORDS; w++) push_write(pool[i], w, rand_param(w));

    // Directed: fresh state, input extremes, unmapped words, refractory clamps,
    // saturating parameters.
    push_beat(CMD_STEP, 0, 1'b0, '0, '0, '0, '0, 0, '0);
    push_beat(CMD_STEP, 0, 1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h7fff_ffff, 31, 32'hffff_ffff);
    push_beat(CMD_STEP, NEURONS - 1, 1'b1, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 0, '0);
    push_write(NEURONS - 1, 31, 32'h1234_5678);
    push_write(NEURONS - 1, WORDS, 32'h8765_4321);
    push_write(NEURONS - 1, W_TREF, 32'h7fff_ffff);
    push_step(NEURONS - 1, 1'b1);
    push_step(NEURONS - 1, 1'b0);
    push_write(NEURONS - 1, W_TREF, 32'h8000_0000);
    push_step(NEURONS - 1, 1'b1);
    push_write(0, W_DECAY, 32'h7fff_ffff);
    push_write(0, W_ASF, 32'h7fff_ffff);
    push_write(0, W_RCOEF, 32'h7fff_ffff);
    push_step(0, 1'b1);
    push_write(0, W_DECAY, 32'h8000_0000);
    push_write(0, W_AAMP, 32'h8000_0000);
    push_step(0, 1'b1);
    push_step(0, 1'b0);
    drain();

    cfg_write(CFG_SPARE, $urandom());
    random_phase();
    drain();

    cfg_write(CFG_HARD_RESET, 32'h1);
    cfg_write(CFG_STEP_SIZE, 32'h0);
    cfg_write(CFG_RESET_V, 32'h8000_0000);
    random_phase();
    drain();

    cfg_write(CFG_HARD_RESET, 32'hffff_fffe);
    cfg_write(CFG_STEP_SIZE, 32'hffff_ffff);
    cfg_write(CFG_RESET_V, 32'h7fff_ffff);
    random_phase();
    drain();

    cfg_write(CFG_HARD_RESET, 32'h1);
    cfg_write(CFG_STEP_SIZE, 32'd65536 + $urandom_range(0, 1 << 17) - (1 << 16)
              + ($urandom_range(0, 1) << 31));
    cfg_write(CFG_RESET_V, rand_syn());
    random_phase();
    drain();

    if (expected_states.size() != 0) begin
      errors++;
      $display("%0t leftover expectations: expected 0 actual %0d", $time,
               expected_states.size());
    end
    $display("covered %0d neuron steps (%0d with spike) and %0d parameter writes",
             n_steps, n_spikes, n_writes);
    $display("under four register settings; %0d results checked, %0d errors",
             n_results, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
